/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock, disabled while the given reset is low.
`define BSES_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on clk_i, disabled while rst_ni is low.
`define BSES_ASSERT(label, prop, msg) \
  `BSES_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/bses_pkg.sv */
// Package for the best satellite elevation select block: widths and constants.
// Used by the top level, the square root unit and the port checker.
package bses_pkg;

  localparam int MaxSats  = 64;
  localparam int CoordW   = 31;
  localparam int IdxW     = 6;
  localparam int MaskW    = 15;
  localparam int ElevW    = 16;
  localparam int RadW     = 64;
  localparam int RootW    = 32;
  localparam int MulW     = 34;
  localparam int ProdW    = 2 * MulW;

  localparam logic [14:0] ElevMax    = 15'd23040;
  localparam logic [16:0] SineOne    = 17'd65536;
  localparam logic [16:0] RadPerStep = 17'd73204;
  localparam logic [30:0] Q30One     = 31'h4000_0000;

  // Reciprocals for the Horner divisions by 110, 72, 42, 20 and 6.
  // Each is ceil(2^(32+l)/d) with l = ceil(log2 d), exact for 32-bit dividends.
  localparam logic [32:0] HornerMul [5] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam logic [6:0] HornerShift [5] = '{7'd39, 7'd39, 7'd38, 7'd37, 7'd35};

endpackage

/* rtl/best_satellite_elevation_select_unit.sv */
// Best satellite elevation select: top level with sequencer and shared multiplier.
// Depends on bses_pkg and bses_isqrt.
//
// Usage: satellite positions arrive on the input channel (in_valid_i / in_stall_o),
// one item per satellite, with last_i marking the end of a scan. The result
// channel (out_valid_o / out_stall_i) carries one item per scan: the index of the
// highest satellite at or above the mask, a found flag and its elevation.
// The station position and the mask are to be written over the APB port only
// while idle; the block itself does not enforce it. Each item runs through one
// 34x34 multiplier under a sequencer: nine products for the dot product and
// squared lengths, two 32-step square roots, a 17-step division (skipped when
// the ratio reaches one) and a bisection of up to 15 steps on the arcsine.
// in_stall_o stays high from an accepted item until the sequencer is back in idle.
// An item whose station or line-of-sight length is zero ends after the square roots.
// The result is held in an output register; a new scan may start while it waits.
// If the receiver stalls and a second result is ready, the block waits for it.
// Reset clears the scan state and the output valid and loads the register resets.
module best_satellite_elevation_select_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bses_pkg::CoordW-1:0]  sat_x_i,
  input  logic signed [bses_pkg::CoordW-1:0]  sat_y_i,
  input  logic signed [bses_pkg::CoordW-1:0]  sat_z_i,
  input  logic        [bses_pkg::IdxW-1:0]    sat_index_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [bses_pkg::IdxW-1:0]    best_index_o,
  output logic                                found_o,
  output logic signed [bses_pkg::ElevW-1:0]   best_elevation_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [3:0]                   paddr,
  input  logic        [31:0]                  pwdata,
  output logic        [31:0]                  prdata,
  output logic                                pready
);
  import bses_pkg::*;

  localparam logic [1:0] RegStationX = 2'd0;
  localparam logic [1:0] RegStationY = 2'd1;
  localparam logic [1:0] RegStationZ = 2'd2;
  localparam logic [1:0] RegMask     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_MAC, S_SQG, S_SQGW, S_SQV, S_SQVW, S_DEN, S_DENR, S_DCMP,
    S_DIV, S_DRND, S_BIS, S_SX, S_SXR, S_SXX, S_SXXR, S_HA, S_HB, S_HC,
    S_SO, S_SOR, S_UPD, S_FIN
  } state_e;

  // Configuration registers.
  logic signed [CoordW-1:0] stx_q, sty_q, stz_q;
  logic        [MaskW-1:0]  mask_q;

  // Sequencer and datapath registers.
  state_e                   state_q;
  logic        [4:0]        cnt_q;
  logic signed [31:0]       vx_q, vy_q, vz_q;
  logic        [IdxW-1:0]   idx_q;
  logic                     last_q;
  logic signed [ProdW-1:0]  p_q;
  logic signed [65:0]       dot_q;
  logic        [63:0]       g2_q, v2_q;
  logic        [31:0]       gm_q, vm_q;
  logic        [63:0]       den_q;
  logic        [65:0]       num_q;
  logic        [16:0]       quo_q;
  logic        [16:0]       mag_q;
  logic                     neg_q;
  logic        [14:0]       lo_q, hi_q, mid_q;
  logic        [31:0]       x_q, x2_q;
  logic        [30:0]       t_q;
  logic signed [ElevW-1:0]  elev_q;
  logic signed [ElevW-1:0]  best_elev_q;
  logic        [IdxW-1:0]   best_sat_q;
  logic                     have_q;
  logic                     out_valid_q;
  logic        [IdxW-1:0]   out_idx_q;
  logic                     out_found_q;
  logic signed [ElevW-1:0]  out_elev_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic                     sq_start;
  logic        [RadW-1:0]   sq_rad;
  logic                     sq_done;
  logic        [RootW-1:0]  sq_root;
  logic        [65:0]       div_sh;
  logic        [ProdW-1:0]  hq;
  logic        [31:0]       sine_s;
  logic        [15:0]       mid_sum;
  logic                     cfg_wr;

  // APB configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stx_q  <= '0;
      sty_q  <= '0;
      stz_q  <= '0;
      mask_q <= MaskW'(2560);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegStationX: stx_q  <= pwdata[CoordW-1:0];
        RegStationY: sty_q  <= pwdata[CoordW-1:0];
        RegStationZ: stz_q  <= pwdata[CoordW-1:0];
        RegMask:     mask_q <= pwdata[MaskW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegStationX: prdata = {{(32-CoordW){stx_q[CoordW-1]}}, stx_q};
      RegStationY: prdata = {{(32-CoordW){sty_q[CoordW-1]}}, sty_q};
      RegStationZ: prdata = {{(32-CoordW){stz_q[CoordW-1]}}, stz_q};
      RegMask:     prdata = {{(32-MaskW){1'b0}}, mask_q};
      default:     prdata = '0;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MAC: begin
        case (cnt_q)
          5'd0: begin mul_a = MulW'(vx_q); mul_b = MulW'(stx_q); end
          5'd1: begin mul_a = MulW'(vy_q); mul_b = MulW'(sty_q); end
          5'd2: begin mul_a = MulW'(vz_q); mul_b = MulW'(stz_q); end
          5'd3: begin mul_a = MulW'(stx_q); mul_b = MulW'(stx_q); end
          5'd4: begin mul_a = MulW'(sty_q); mul_b = MulW'(sty_q); end
          5'd5: begin mul_a = MulW'(stz_q); mul_b = MulW'(stz_q); end
          5'd6: begin mul_a = MulW'(vx_q); mul_b = MulW'(vx_q); end
          5'd7: begin mul_a = MulW'(vy_q); mul_b = MulW'(vy_q); end
          5'd8: begin mul_a = MulW'(vz_q); mul_b = MulW'(vz_q); end
          default: ;
        endcase
      end
      S_DEN: begin
        mul_a = $signed({2'b00, gm_q});
        mul_b = $signed({2'b00, vm_q});
      end
      S_SX: begin
        mul_a = $signed({19'd0, mid_q});
        mul_b = $signed({17'd0, RadPerStep});
      end
      S_SXX: begin
        mul_a = $signed({2'b00, x_q});
        mul_b = $signed({2'b00, x_q});
      end
      S_HA: begin
        mul_a = $signed({2'b00, x2_q});
        mul_b = $signed({3'b000, t_q});
      end
      S_HB: begin
        mul_a = $signed({2'b00, p_q[61:30]});
        mul_b = $signed({1'b0, HornerMul[cnt_q[2:0]]});
      end
      S_SO: begin
        mul_a = $signed({2'b00, x_q});
        mul_b = $signed({3'b000, t_q});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Square root unit, shared between the station and the line-of-sight lengths.
  assign sq_start = (state_q == S_SQG) || (state_q == S_SQV);
  assign sq_rad   = (state_q == S_SQG) ? g2_q : v2_q;

  bses_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // Helpers for the division, Horner and bisection steps.
  assign div_sh  = {num_q[64:0], 1'b0};
  assign hq      = p_q >> HornerShift[cnt_q[2:0]];
  assign sine_s  = (p_q[61:30] + 32'd8192) >> 14;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 16'd1;

  // Sequencer with datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      p_q         <= '0;
      dot_q       <= '0;
      g2_q        <= '0;
      v2_q        <= '0;
      gm_q        <= '0;
      vm_q        <= '0;
      den_q       <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      x_q         <= '0;
      x2_q        <= '0;
      t_q         <= '0;
      elev_q      <= '0;
      best_elev_q <= '0;
      best_sat_q  <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_found_q <= 1'b0;
      out_elev_q  <= '0;
    end else begin
      p_q <= mul_p;
      // The result register empties on acceptance unless a new result is loaded now.
      if (out_valid_q && !out_stall_i && !(state_q == S_FIN && last_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vx_q   <= 32'(sat_x_i) - 32'(stx_q);
            vy_q   <= 32'(sat_y_i) - 32'(sty_q);
            vz_q   <= 32'(sat_z_i) - 32'(stz_q);
            idx_q  <= sat_index_i;
            last_q <= last_i;
            dot_q  <= '0;
            g2_q   <= '0;
            v2_q   <= '0;
            cnt_q  <= '0;
            if (32'(sat_index_i) < 32'(MaxSats)) begin
              state_q <= S_MAC;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        // Nine products, each accumulated in the cycle after it is formed.
        S_MAC: begin
          if (cnt_q >= 5'd1 && cnt_q <= 5'd3) begin
            dot_q <= dot_q + p_q[65:0];
          end else if (cnt_q >= 5'd4 && cnt_q <= 5'd6) begin
            g2_q <= g2_q + p_q[63:0];
          end else if (cnt_q >= 5'd7) begin
            v2_q <= v2_q + p_q[63:0];
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd9) begin
            state_q <= S_SQG;
          end
        end
        S_SQG: state_q <= S_SQGW;
        S_SQGW: begin
          if (sq_done) begin
            gm_q    <= sq_root;
            state_q <= S_SQV;
          end
        end
        S_SQV: state_q <= S_SQVW;
        // A zero length makes the satellite invisible.
        S_SQVW: begin
          if (sq_done) begin
            vm_q <= sq_root;
            if (gm_q == '0 || sq_root == '0) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_DEN;
            end
          end
        end
        S_DEN: state_q <= S_DENR;
        S_DENR: begin
          den_q   <= p_q[63:0];
          neg_q   <= dot_q[65];
          num_q   <= dot_q[65] ? 66'(-dot_q) : 66'(dot_q);
          state_q <= S_DCMP;
        end
        S_DCMP: begin
          lo_q <= '0;
          hi_q <= ElevMax;
          if (num_q >= {2'b00, den_q}) begin
            mag_q   <= SineOne;
            state_q <= S_BIS;
          end else begin
            cnt_q   <= '0;
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        // Restoring division, one quotient bit a cycle.
        S_DIV: begin
          if (div_sh >= {2'b00, den_q}) begin
            num_q <= div_sh - {2'b00, den_q};
            quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            num_q <= div_sh;
            quo_q <= {quo_q[15:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            state_q <= S_DRND;
          end
        end
        S_DRND: begin
          mag_q   <= 17'(({1'b0, quo_q} + 18'd1) >> 1);
          state_q <= S_BIS;
        end
        // Bisection for the largest elevation whose sine does not exceed the target.
        S_BIS: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_sum[15:1];
            state_q <= S_SX;
          end else begin
            elev_q  <= neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});
            state_q <= S_UPD;
          end
        end
        S_SX: state_q <= S_SXR;
        S_SXR: begin
          x_q     <= p_q[31:0];
          state_q <= S_SXX;
        end
        S_SXX: state_q <= S_SXXR;
        S_SXXR: begin
          x2_q    <= p_q[61:30];
          t_q     <= Q30One;
          cnt_q   <= '0;
          state_q <= S_HA;
        end
        S_HA: state_q <= S_HB;
        S_HB: state_q <= S_HC;
        S_HC: begin
          t_q <= Q30One - hq[30:0];
          if (cnt_q == 5'd4) begin
            state_q <= S_SO;
          end else begin
            cnt_q   <= cnt_q + 5'd1;
            state_q <= S_HA;
          end
        end
        S_SO: state_q <= S_SOR;
        S_SOR: begin
          if (sine_s <= 32'(mag_q)) begin
            lo_q <= mid_q;
          end else begin
            hi_q <= mid_q - 15'd1;
          end
          state_q <= S_BIS;
        end
        // Keep the first satellite with the highest elevation at or above the mask.
        S_UPD: begin
          if (elev_q >= $signed({1'b0, mask_q}) && (!have_q || elev_q > best_elev_q)) begin
            best_elev_q <= elev_q;
            best_sat_q  <= idx_q;
            have_q      <= 1'b1;
          end
          state_q <= S_FIN;
        end
        // Last item of a scan: emit one result item once the output register is free.
        S_FIN: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= have_q ? best_sat_q : '0;
            out_found_q <= have_q;
            out_elev_q  <= have_q ? best_elev_q : '0;
            best_elev_q <= '0;
            best_sat_q  <= '0;
            have_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign best_index_o     = out_idx_q;
  assign found_o          = out_found_q;
  assign best_elevation_o = out_elev_q;

endmodule

/* rtl/bses_isqrt.sv */
// Bit-serial floor integer square root of a 64-bit radicand, one result bit a cycle.
// Depends on bses_pkg for the radicand and root widths.
module bses_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bses_pkg::RadW-1:0]  rad_i,
  output logic                       done_o,
  output logic [bses_pkg::RootW-1:0] root_o
);
  import bses_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [4:0]      cnt_q;
  logic [RadW-1:0] n_q;
  logic [RadW-1:0] res_q;
  logic [RadW-1:0] bit_q;
  logic [RadW-1:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

  // One restoring step per cycle; the trial bit moves down two places each time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= rad_i;
        res_q  <= '0;
        bit_q  <= RadW'(1) << (RadW - 2);
      end else if (busy_q) begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/bses_checker.sv */
// Port-level checker for the best satellite elevation select block, with its bind.
// Depends on bses_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bses_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic        [bses_pkg::IdxW-1:0]   best_index_o,
  input logic                               found_o,
  input logic signed [bses_pkg::ElevW-1:0]  best_elevation_o
);
  import bses_pkg::*;

  // A stalled result item stays offered.
  `BSES_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // An accepted item keeps the input busy on the next cycle.
  `BSES_ASSERT(a_in_busy, in_valid_i && !in_stall_o |=> in_stall_o, "input taken back to back")

  // An empty scan reports zero index and zero elevation.
  `BSES_ASSERT(a_none_zero, out_valid_o && !found_o |-> best_index_o == '0 && best_elevation_o == '0, "empty result not cleared")

  // A found elevation lies between zero and ninety degrees.
  `BSES_ASSERT(a_elev_range, out_valid_o && found_o |-> !best_elevation_o[ElevW-1] && best_elevation_o <= $signed({1'b0, ElevMax}), "elevation out of range")

endmodule

bind best_satellite_elevation_select_unit bses_checker u_bses_checker (.*);
